[design/chm_pkg.sv]
// Shared constants, codes and hash step for the chained hash map engine.
`default_nettype none

package chm_pkg;

   localparam int DEF_ENTRY_SLOTS = 64;
   localparam int DEF_MAX_BUCKETS = 64;
   localparam int KEY_BYTES       = 8;
   localparam int VALUE_BYTES     = 8;

   localparam logic [31:0] HASH_SEED = 32'h1234_5678;
   localparam logic [31:0] HASH_ADD  = 32'ha1b2_c3d4;

   localparam logic [6:0] CSR_BUCKETS_RESET = 7'd8;
   localparam logic [6:0] CSR_BUCKETS_ZERO  = 7'd8;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // One byte of the key hash: rotate left by 7, add, mix in byte and old hash.
   function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] rot;
      rot = {h[24:0], h[31:25]};
      return ((rot + HASH_ADD) ^ {24'd0, b}) ^ h;
   endfunction

   // Keep the low n bytes of a 64-bit word.
   function automatic logic [63:0] byte_mask(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < n) begin
            m[i*8 +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

[design/chm_hash.sv]
// Byte-serial key hash followed by a bit-serial reduction modulo the bucket count.
`default_nettype none

module chm_hash #(
   parameter int MAX_BUCKETS = chm_pkg::DEF_MAX_BUCKETS,
   parameter int CNT_W = $clog2(MAX_BUCKETS + 1),
   parameter int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [63:0]      key,
   input  wire logic [3:0]       key_len,
   input  wire logic [CNT_W-1:0] bucket_cnt,
   output logic                  done,
   output logic [31:0]           hash,
   output logic [BKT_W-1:0]      bucket
);
   import chm_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HASH = 2'd1;
   localparam logic [1:0] PH_MOD  = 2'd2;

   logic [1:0]     phase_ff, phase_in;
   logic [3:0]     idx_ff, idx_in;
   logic [63:0]    krem_ff, krem_in;
   logic [31:0]    h_ff, h_in;
   logic [CNT_W:0] rem_ff, rem_in;
   logic [4:0]     bit_ff, bit_in;
   logic           done_ff, done_in;
   logic [CNT_W:0] rem_shift;

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      krem_in   = krem_ff;
      h_in      = h_ff;
      rem_in    = rem_ff;
      bit_in    = bit_ff;
      done_in   = 1'b0;
      rem_shift = {rem_ff[CNT_W-1:0], h_ff[bit_ff]};
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               h_in     = HASH_SEED;
               krem_in  = key;
               idx_in   = key_len;
               rem_in   = '0;
               bit_in   = 5'd31;
               phase_in = (key_len == 4'd0) ? PH_MOD : PH_HASH;
            end
         end
         PH_HASH: begin
            h_in    = hash_step(h_ff, krem_ff[7:0]);
            krem_in = krem_ff >> 8;
            idx_in  = idx_ff - 4'd1;
            if (idx_ff == 4'd1) begin
               phase_in = PH_MOD;
            end
         end
         PH_MOD: begin
            // restoring remainder, one hash bit per cycle from the top
            if (rem_shift >= {1'b0, bucket_cnt}) begin
               rem_in = rem_shift - {1'b0, bucket_cnt};
            end else begin
               rem_in = rem_shift;
            end
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      idx_ff  <= idx_in;
      krem_ff <= krem_in;
      h_ff    <= h_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
   end

   assign done   = done_ff;
   assign hash   = h_ff;
   assign bucket = BKT_W'(rem_ff);

endmodule

`default_nettype wire

[design/chained_hash_map_engine.sv]
// Chained hash map engine: hash unit, bucket and entry memories, chain-walk sequencer.
//
// Key/value store with separate chaining. One request beat on req_ is an insert,
// lookup or remove; each request gives exactly one response beat on rsp_, in order.
// csr_ writes the bucket count (zero acts as 8, values above MAX_BUCKETS saturate);
// write it only while no request is in flight.
// Each request is accepted, its key is hashed one byte a cycle, the hash is reduced by
// the bit-serial modulo by the bucket count, the bucket head is read, the chain is
// walked entry by entry, then the memories are updated where the operation needs it
// and the result goes into the response register. The hash and modulo unit takes
// most of the time of a request.
// Requests are served one at a time; the next request is accepted as soon as the
// sequencer is idle, even while the previous response still waits in rsp_.
// After reset the bucket head memory is swept to empty, one bucket a cycle, over all
// MAX_BUCKETS entries; req_tready stays low meanwhile, csr_ writes are taken.
// When the receiver stalls, the response holds in its register and a finished
// request waits in the sequencer until the register frees.
`default_nettype none

module chained_hash_map_engine #(
   parameter int ENTRY_SLOTS = chm_pkg::DEF_ENTRY_SLOTS,
   parameter int MAX_BUCKETS = chm_pkg::DEF_MAX_BUCKETS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // operation[1:0], key[65:2], key_length[69:66], value[133:70],
   // value_length[137:134], zero fill [143:138]
   input  wire logic [143:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[1:0], found_value[65:2], found_value_length[69:66],
   // key_hash[101:70], zero fill [103:102]
   output logic [103:0]      rsp_tdata,
   input  wire logic         csr_tvalid,
   output logic              csr_tready,
   // bucket_count[6:0], zero fill [7]
   input  wire logic [7:0]   csr_tdata
);
   import chm_pkg::*;

   localparam int SLOT_W = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
   localparam int LINK_W = $clog2(ENTRY_SLOTS + 1);
   localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
   localparam int EW     = LINK_W + 136;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(ENTRY_SLOTS);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_HASH  = 4'd2;
   localparam logic [3:0] S_HEAD  = 4'd3;
   localparam logic [3:0] S_CMP   = 4'd4;
   localparam logic [3:0] S_FREE  = 4'd5;
   localparam logic [3:0] S_ALLOC = 4'd6;
   localparam logic [3:0] S_POP   = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   // entry word: next link on top, then key, key length, value, value length
   logic [EW-1:0] entry_mem [ENTRY_SLOTS];
   logic [LINK_W-1:0] head_mem [MAX_BUCKETS];

   logic [3:0]        state_ff, state_in;
   logic [6:0]        bc_ff, bc_in;
   logic [1:0]        op_ff, op_in;
   logic [63:0]       key_ff, key_in;
   logic [3:0]        klen_ff, klen_in;
   logic [63:0]       val_ff, val_in;
   logic [3:0]        vlen_ff, vlen_in;
   logic [BKT_W-1:0]  bucket_ff, bucket_in;
   logic [31:0]       hash_ff, hash_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic [EW-1:0]     prev_word_ff, prev_word_in;
   logic [LINK_W-1:0] head_link_ff, head_link_in;
   logic [LINK_W-1:0] free_head_ff, free_head_in;
   logic [LINK_W-1:0] alloc_ff, alloc_in;
   logic [BKT_W-1:0]  clr_ff, clr_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [63:0]       res_val_ff, res_val_in;
   logic [3:0]        res_vlen_ff, res_vlen_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [103:0]      rsp_data_ff, rsp_data_in;

   logic              ent_we, ent_re;
   logic [SLOT_W-1:0] ent_waddr, ent_raddr;
   logic [EW-1:0]     ent_wdata, entry_rd_ff;
   logic              head_we, head_re;
   logic [BKT_W-1:0]  head_waddr, head_raddr;
   logic [LINK_W-1:0] head_wdata, head_rd_ff;

   logic              hash_start, hash_done;
   logic [31:0]       hash_val;
   logic [BKT_W-1:0]  hash_bucket;
   logic [10:0]       bc_act;
   logic [CNT_W-1:0]  bucket_cnt;

   logic [3:0]        in_klen, in_vlen;
   logic [LINK_W-1:0] rd_next;
   logic              key_match;
   logic [135:0]      new_body;

   // active bucket count: zero means 8, saturate at the memory depth
   always_comb begin
      bc_act = (bc_ff == 7'd0) ? {4'd0, CSR_BUCKETS_ZERO} : {4'd0, bc_ff};
      if (bc_act > 11'(MAX_BUCKETS)) begin
         bc_act = 11'(MAX_BUCKETS);
      end
      bucket_cnt = CNT_W'(bc_act);
   end

   chm_hash #(
      .MAX_BUCKETS(MAX_BUCKETS),
      .CNT_W      (CNT_W),
      .BKT_W      (BKT_W)
   ) u_hash (
      .clock     (clock),
      .reset     (reset),
      .start     (hash_start),
      .key       (key_in),
      .key_len   (klen_in),
      .bucket_cnt(bucket_cnt),
      .done      (hash_done),
      .hash      (hash_val),
      .bucket    (hash_bucket)
   );

   assign in_klen = (req_tdata[69:66] > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : req_tdata[69:66];
   assign in_vlen = (req_tdata[137:134] > 4'(VALUE_BYTES)) ?
                    4'(VALUE_BYTES) : req_tdata[137:134];

   assign rd_next   = entry_rd_ff[EW-1:136];
   assign key_match = (entry_rd_ff[71:68] == klen_ff) && (entry_rd_ff[135:72] == key_ff);
   assign new_body  = {key_ff, klen_ff, val_ff, vlen_ff};

   assign req_tready = (state_ff == S_IDLE);
   assign csr_tready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      bc_in         = (csr_tvalid) ? csr_tdata[6:0] : bc_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      klen_in       = klen_ff;
      val_in        = val_ff;
      vlen_in       = vlen_ff;
      bucket_in     = bucket_ff;
      hash_in       = hash_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_word_in  = prev_word_ff;
      head_link_in  = head_link_ff;
      free_head_in  = free_head_ff;
      alloc_in      = alloc_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_val_in    = res_val_ff;
      res_vlen_in   = res_vlen_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ent_we        = 1'b0;
      ent_re        = 1'b0;
      ent_waddr     = '0;
      ent_raddr     = '0;
      ent_wdata     = '0;
      head_we       = 1'b0;
      head_re       = 1'b0;
      head_waddr    = '0;
      head_raddr    = '0;
      head_wdata    = NIL;
      hash_start    = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            // sweep every bucket to an empty chain
            head_we    = 1'b1;
            head_waddr = clr_ff;
            if (clr_ff == BKT_W'(MAX_BUCKETS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in         = req_tdata[1:0];
               key_in        = req_tdata[65:2] & byte_mask(in_klen);
               klen_in       = in_klen;
               val_in        = req_tdata[133:70] & byte_mask(in_vlen);
               vlen_in       = in_vlen;
               res_status_in = ST_MISS;
               res_val_in    = '0;
               res_vlen_in   = '0;
               hash_start    = 1'b1;
               state_in      = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               hash_in    = hash_val;
               bucket_in  = hash_bucket;
               head_re    = 1'b1;
               head_raddr = hash_bucket;
               state_in   = S_HEAD;
            end
         end
         S_HEAD: begin
            head_link_in = head_rd_ff;
            cur_in       = head_rd_ff;
            prev_in      = NIL;
            if (head_rd_ff == NIL) begin
               state_in = S_ALLOC;
            end else begin
               ent_re    = 1'b1;
               ent_raddr = head_rd_ff[SLOT_W-1:0];
               state_in  = S_CMP;
            end
         end
         S_CMP: begin
            if (key_match) begin
               state_in = S_DONE;
               case (op_ff)
                  OP_LOOKUP: begin
                     res_status_in = ST_DONE;
                     res_val_in    = entry_rd_ff[67:4];
                     res_vlen_in   = entry_rd_ff[3:0];
                  end
                  OP_INSERT: begin
                     // replace in place: same key, same chain
                     ent_we        = 1'b1;
                     ent_waddr     = cur_ff[SLOT_W-1:0];
                     ent_wdata     = {rd_next, new_body};
                     res_status_in = ST_DONE;
                  end
                  OP_REMOVE: begin
                     // unlink from predecessor or bucket head
                     if (prev_ff == NIL) begin
                        head_we    = 1'b1;
                        head_waddr = bucket_ff;
                        head_wdata = rd_next;
                     end else begin
                        ent_we    = 1'b1;
                        ent_waddr = prev_ff[SLOT_W-1:0];
                        ent_wdata = {rd_next, prev_word_ff[135:0]};
                     end
                     state_in = S_FREE;
                  end
                  default: begin
                     res_status_in = ST_MISS;
                  end
               endcase
            end else begin
               prev_in      = cur_ff;
               prev_word_in = entry_rd_ff;
               cur_in       = rd_next;
               if (rd_next == NIL) begin
                  state_in = S_ALLOC;
               end else begin
                  ent_re    = 1'b1;
                  ent_raddr = rd_next[SLOT_W-1:0];
               end
            end
         end
         S_FREE: begin
            // push the released slot onto the free list
            ent_we        = 1'b1;
            ent_waddr     = cur_ff[SLOT_W-1:0];
            ent_wdata     = {free_head_ff, entry_rd_ff[135:0]};
            free_head_in  = cur_ff;
            res_status_in = ST_DONE;
            state_in      = S_DONE;
         end
         S_ALLOC: begin
            state_in = S_DONE;
            if (op_ff == OP_INSERT) begin
               if (free_head_ff != NIL) begin
                  ent_re    = 1'b1;
                  ent_raddr = free_head_ff[SLOT_W-1:0];
                  state_in  = S_POP;
               end else if (alloc_ff != NIL) begin
                  ent_we        = 1'b1;
                  ent_waddr     = alloc_ff[SLOT_W-1:0];
                  ent_wdata     = {head_link_ff, new_body};
                  head_we       = 1'b1;
                  head_waddr    = bucket_ff;
                  head_wdata    = alloc_ff;
                  alloc_in      = alloc_ff + 1'b1;
                  res_status_in = ST_DONE;
               end else begin
                  res_status_in = ST_FULL;
               end
            end else begin
               res_status_in = ST_MISS;
            end
         end
         S_POP: begin
            free_head_in  = rd_next;
            ent_we        = 1'b1;
            ent_waddr     = free_head_ff[SLOT_W-1:0];
            ent_wdata     = {head_link_ff, new_body};
            head_we       = 1'b1;
            head_waddr    = bucket_ff;
            head_wdata    = free_head_ff;
            res_status_in = ST_DONE;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // hand over once the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, hash_ff, res_vlen_ff, res_val_ff, res_status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem[ent_waddr] <= ent_wdata;
      end
      if (ent_re) begin
         entry_rd_ff <= entry_mem[ent_raddr];
      end
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      if (head_re) begin
         head_rd_ff <= head_mem[head_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         bc_ff        <= CSR_BUCKETS_RESET;
         clr_ff       <= '0;
         free_head_ff <= NIL;
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bc_ff        <= bc_in;
         clr_ff       <= clr_in;
         free_head_ff <= free_head_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      klen_ff       <= klen_in;
      val_ff        <= val_in;
      vlen_ff       <= vlen_in;
      bucket_ff     <= bucket_in;
      hash_ff       <= hash_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_word_ff  <= prev_word_in;
      head_link_ff  <= head_link_in;
      res_status_ff <= res_status_in;
      res_val_ff    <= res_val_in;
      res_vlen_ff   <= res_vlen_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[design/chm_checker.sv]
// Port-level assertions for the chained hash map engine, bound to the top level.
`default_nettype none

module chm_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [103:0] rsp_tdata
);
   import chm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat dropped or changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == ST_DONE) || (rsp_tdata[1:0] == ST_MISS)
                     || (rsp_tdata[1:0] == ST_FULL))
      else $error("undefined status code");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_DONE |-> rsp_tdata[69:2] == '0)
      else $error("value returned with a miss or full status");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[69:66] <= 4'(VALUE_BYTES))
      else $error("value length beyond limit");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid straight after reset");

endmodule

bind chained_hash_map_engine chm_checker u_chm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire

[test/chained_hash_map_engine_tb.sv]
// Testbench for the chained hash map engine: directed and random operations checked beat by beat.
`timescale 1ns / 100ps

// Predicts each response from its own copy of the table and checks responses in order.
class chm_scoreboard;
   logic [6:0]  bucket_cfg;
   int          head_of[64];
   int          next_of[64];
   logic [63:0] key_of[64];
   logic [3:0]  klen_of[64];
   logic [63:0] val_of[64];
   logic [3:0]  vlen_of[64];
   bit          busy_of[64];
   logic [103:0] pending_rsp[$];
   int          errors;
   int          hits;
   int          fulls;

   function new();
      bucket_cfg = 7'd8;
      errors = 0;
      hits = 0;
      fulls = 0;
      for (int i = 0; i < 64; i++) begin
         head_of[i] = 64;
         next_of[i] = 64;
         busy_of[i] = 0;
      end
   endfunction

   function void set_buckets(logic [6:0] bc);
      bucket_cfg = bc;
   endfunction

   function logic [31:0] hash_key(logic [63:0] k, logic [3:0] n);
      logic [31:0] h;
      logic [31:0] r;
      h = 32'h1234_5678;
      for (int i = 0; i < n; i++) begin
         r = {h[24:0], h[31:25]};
         h = ((r + 32'ha1b2_c3d4) ^ {24'd0, k[i*8 +: 8]}) ^ h;
      end
      return h;
   endfunction

   function logic [63:0] low_bytes(logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < n; i++) m[i*8 +: 8] = 8'hff;
      return m;
   endfunction

   // Note an accepted request beat and queue its expected response.
   function void note_request(logic [143:0] d);
      logic [1:0]  op;
      logic [63:0] k;
      logic [63:0] v;
      logic [3:0]  kl;
      logic [3:0]  vl;
      logic [31:0] h;
      int          nb;
      int          b;
      int          cur;
      int          prv;
      int          hit;
      int          slot;
      logic [1:0]  st;
      logic [63:0] fv;
      logic [3:0]  fl;
      op = d[1:0];
      kl = d[69:66];
      vl = d[137:134];
      if (kl > 8) kl = 8;
      if (vl > 8) vl = 8;
      k = d[65:2] & low_bytes(kl);
      v = d[133:70] & low_bytes(vl);
      h = hash_key(k, kl);
      nb = (bucket_cfg == 0) ? 8 : ((bucket_cfg > 64) ? 64 : bucket_cfg);
      b = h % nb;
      cur = head_of[b];
      prv = 64;
      hit = 64;
      for (int s = 0; s < 64 && cur < 64; s++) begin
         if (klen_of[cur] == kl && key_of[cur] == k) begin
            hit = cur;
            break;
         end
         prv = cur;
         cur = next_of[cur];
      end
      st = chm_pkg::ST_MISS;
      fv = '0;
      fl = '0;
      if (hit < 64 && (op == chm_pkg::OP_INSERT || op == chm_pkg::OP_REMOVE)) begin
         if (prv < 64) next_of[prv] = next_of[hit];
         else head_of[b] = next_of[hit];
         busy_of[hit] = 0;
         if (op == chm_pkg::OP_REMOVE) st = chm_pkg::ST_DONE;
      end
      if (op == chm_pkg::OP_INSERT) begin
         slot = 64;
         for (int i = 0; i < 64; i++) begin
            if (!busy_of[i]) begin
               slot = i;
               break;
            end
         end
         if (slot < 64) begin
            busy_of[slot] = 1;
            key_of[slot] = k;
            klen_of[slot] = kl;
            val_of[slot] = v;
            vlen_of[slot] = vl;
            next_of[slot] = head_of[b];
            head_of[b] = slot;
            st = chm_pkg::ST_DONE;
         end else begin
            st = chm_pkg::ST_FULL;
            fulls++;
         end
      end else if (op == chm_pkg::OP_LOOKUP && hit < 64) begin
         st = chm_pkg::ST_DONE;
         fv = val_of[hit];
         fl = vlen_of[hit];
         hits++;
      end
      pending_rsp.push_back({2'b00, h, fl, fv, st});
   endfunction

   // Compare a response beat field by field with the oldest expectation.
   task check_response(logic [103:0] got);
      logic [103:0] want;
      if (pending_rsp.size() == 0) begin
         report_mismatch("response with nothing expected", got, '0);
      end else begin
         want = pending_rsp.pop_front();
         if (got[1:0] !== want[1:0]) report_mismatch("status", got, want);
         if (got[65:2] !== want[65:2]) report_mismatch("found_value", got, want);
         if (got[69:66] !== want[69:66]) report_mismatch("found_value_length", got, want);
         if (got[101:70] !== want[101:70]) report_mismatch("key_hash", got, want);
      end
   endtask

   task report_mismatch(string what, logic [103:0] got, logic [103:0] want);
      errors++;
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
   endtask
endclass

module chained_hash_map_engine_tb;
   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic         csr_tvalid;
   logic         csr_tready;
   logic [7:0]   csr_tdata;

   chm_scoreboard table_model;
   longint       cycle_count;
   bit           hold_off;
   int           responses_seen;
   logic [63:0]  key_pool[16];
   logic [3:0]   klen_pool[16];

   chained_hash_map_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Watchdog: stop a hung run well past the slowest correct one.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
      return $urandom_range(0, 4);
   endfunction

   // Drive one request beat and hold it until the block takes it.
   task automatic send_request(logic [1:0] op, logic [63:0] k, logic [3:0] kl,
                               logic [63:0] v, logic [3:0] vl);
      @(negedge clock);
      req_tdata  <= {6'd0, vl, v, kl, k, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      table_model.note_request({6'd0, vl, v, kl, k, op});
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (gap_length()) @(negedge clock);
   endtask

   // Write the bucket count once every outstanding response has drained.
   task automatic write_buckets(logic [7:0] bc);
      while (table_model.pending_rsp.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      @(negedge clock);
      csr_tdata  <= bc;
      csr_tvalid <= 1'b1;
      do @(posedge clock); while (!csr_tready);
      table_model.set_buckets(bc[6:0]);
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   // Mostly pool-key traffic so chains build up and hit; some beats are random or malformed.
   task automatic random_phase(int count);
      int          p;
      logic [1:0]  op;
      logic [63:0] k;
      logic [3:0]  kl;
      for (int n = 0; n < count; n++) begin
         p = $urandom_range(0, 15);
         k = key_pool[p];
         kl = klen_pool[p];
         case ($urandom_range(0, 9))
            0, 1, 2, 3: op = chm_pkg::OP_INSERT;
            4, 5, 6:    op = chm_pkg::OP_LOOKUP;
            7, 8:       op = chm_pkg::OP_REMOVE;
            default: begin
               op = 2'($urandom_range(0, 3));
               k = {$urandom, $urandom};
               kl = 4'($urandom_range(0, 15));
            end
         endcase
         send_request(op, k, kl, {$urandom, $urandom}, 4'($urandom_range(0, 15)));
      end
   endtask

   // Receiver: random ready, with one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      responses_seen = 0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         if ($urandom_range(0, 30) == 0) begin
            rsp_tready <= 1'b0;
            repeat (gap_length()) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            table_model.check_response(rsp_tdata);
            responses_seen++;
         end
         @(negedge clock);
      end
   end

   initial begin
      table_model = new();
      cycle_count = 0;
      hold_off = 0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_tvalid = 1'b0;
      csr_tdata = '0;
      reset = 1'b1;
      for (int i = 0; i < 16; i++) begin
         key_pool[i] = {$urandom, $urandom};
         klen_pool[i] = 4'($urandom_range(0, 9));
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes of the fields, every operation, miss and bad opcode.
      send_request(chm_pkg::OP_LOOKUP, '0, 4'd0, '0, 4'd0);
      send_request(chm_pkg::OP_INSERT, '0, 4'd0, '1, 4'd8);
      send_request(chm_pkg::OP_LOOKUP, '1, 4'd0, '0, 4'd0);
      send_request(chm_pkg::OP_INSERT, '1, 4'd15, '1, 4'd15);
      send_request(chm_pkg::OP_LOOKUP, '1, 4'd8, '0, 4'd0);
      send_request(chm_pkg::OP_INSERT, '1, 4'd8, 64'h0123_4567_89ab_cdef, 4'd3);
      send_request(chm_pkg::OP_LOOKUP, '1, 4'd12, '1, 4'd15);
      send_request(chm_pkg::OP_INSERT, 64'hffff_ff00_0000_00aa, 4'd1, '1, 4'd0);
      send_request(chm_pkg::OP_LOOKUP, 64'h0000_0000_0000_00aa, 4'd1, '0, 4'd0);
      send_request(2'd3, '1, 4'd8, '1, 4'd8);
      send_request(chm_pkg::OP_REMOVE, '1, 4'd8, '0, 4'd0);
      send_request(chm_pkg::OP_REMOVE, '1, 4'd8, '0, 4'd0);
      send_request(chm_pkg::OP_LOOKUP, '1, 4'd8, '0, 4'd0);

      // Fill the table to overflow, then replace and remove while full.
      write_buckets(8'd1);
      for (int i = 0; i < 66; i++) begin
         send_request(chm_pkg::OP_INSERT, 64'(i), 4'd2, 64'(i * 3), 4'd2);
      end
      send_request(chm_pkg::OP_INSERT, 64'd5, 4'd2, '1, 4'd8);
      send_request(chm_pkg::OP_LOOKUP, 64'd5, 4'd2, '0, 4'd0);
      send_request(chm_pkg::OP_LOOKUP, 64'd63, 4'd2, '0, 4'd0);
      for (int i = 0; i < 64; i++) begin
         send_request(chm_pkg::OP_REMOVE, 64'(i), 4'd2, '0, 4'd0);
      end

      // Random phases across bucket counts, extremes and out-of-range values.
      write_buckets(8'd0);
      random_phase(100);
      write_buckets(8'd64);
      random_phase(100);
      write_buckets(8'h7f);
      hold_off = 1;
      random_phase(100);
      write_buckets(8'd3);
      random_phase(100);
      write_buckets(8'd1);
      random_phase(80);
      write_buckets(8'h80 | 8'd17);
      random_phase(100);

      while (table_model.pending_rsp.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("Run covered %0d responses, %0d lookup hits, %0d full inserts.",
               responses_seen, table_model.hits, table_model.fulls);
      if (table_model.errors == 0 && table_model.pending_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

[chained_hash_map_engine.f]
design/chm_pkg.sv
design/chm_hash.sv
design/chained_hash_map_engine.sv
design/chm_checker.sv
test/chained_hash_map_engine_tb.sv
